FILE: sv/sfa_pkg.sv
// Shared types and constants for the smallest free ID allocator.
// Used by sfa_cell, sfa_chain and smallest_free_id_allocator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

  // Store geometry and ID range.
  localparam int STORE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);

  // Command codes.
  localparam logic CMD_POP = 1'b0;
  localparam logic CMD_ADD = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NO_CHANGE = 2'd3;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;  // Compare the stored ID against the request ID.
    logic ins;  // Insert the request ID in sorted order.
    logic pop;  // Shift every entry one place toward the head.
  } sfa_cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/sfa_cell.sv
// One storage cell of the sorted ID chain: holds one ID and its valid bit.
// Depends on sfa_pkg for the ID width and the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module sfa_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  sfa_pkg::sfa_cell_ctl_t      ctl,
  input  wire [sfa_pkg::ID_BITS-1:0]  req_id,
  input  wire                         left_valid,
  input  wire [sfa_pkg::ID_BITS-1:0]  left_val,
  input  wire                         left_lt,
  input  wire                         right_valid,
  input  wire [sfa_pkg::ID_BITS-1:0]  right_val,
  output logic                        valid,
  output logic [sfa_pkg::ID_BITS-1:0] val,
  output logic                        lt,
  output logic                        eq
);
  import sfa_pkg::*;

  logic               valid_r;
  logic [ID_BITS-1:0] val_r;
  logic               lt_r;
  logic               eq_r;

  // Compare phase: record whether this entry lies below or matches the request.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt_r <= valid_r && (val_r < req_id);
      eq_r <= valid_r && (val_r == req_id);
    end
  end

  // Valid bit: shift toward the head on pop, make room on insert.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.pop) begin
      valid_r <= right_valid;
    end else if (ctl.ins && !lt_r) begin
      valid_r <= left_lt ? 1'b1 : left_valid;
    end
  end

  // Stored ID follows the same moves as the valid bit.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      val_r <= right_val;
    end else if (ctl.ins && !lt_r) begin
      val_r <= left_lt ? req_id : left_val;
    end
  end

  assign valid = valid_r;
  assign val   = val_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

FILE: sv/sfa_chain.sv
// Row of sfa_cell instances kept in ascending order, smallest ID at the head.
// Depends on sfa_pkg and sfa_cell.
`timescale 1ns / 1ps
`default_nettype none

module sfa_chain (
  input  wire                         clk,
  input  wire                         rst_n,
  input  sfa_pkg::sfa_cell_ctl_t      ctl,
  input  wire [sfa_pkg::ID_BITS-1:0]  req_id,
  output logic                        found,
  output logic [sfa_pkg::ID_BITS-1:0] head_val
);
  import sfa_pkg::*;

  logic               valid_a [STORE_DEPTH];
  logic [ID_BITS-1:0] val_a   [STORE_DEPTH];
  logic               lt_a    [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] eq_v;

  // Each cell sees its neighbors; the head treats its left as "below the request"
  // and the tail sees an empty cell on its right.
  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
    logic               l_valid;
    logic [ID_BITS-1:0] l_val;
    logic               l_lt;
    logic               r_valid;
    logic [ID_BITS-1:0] r_val;

    if (g == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_val   = '0;
      assign l_lt    = 1'b1;
    end else begin : g_mid
      assign l_valid = valid_a[g-1];
      assign l_val   = val_a[g-1];
      assign l_lt    = lt_a[g-1];
    end

    if (g == STORE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_val   = '0;
    end else begin : g_body
      assign r_valid = valid_a[g+1];
      assign r_val   = val_a[g+1];
    end

    sfa_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .req_id      (req_id),
      .left_valid  (l_valid),
      .left_val    (l_val),
      .left_lt     (l_lt),
      .right_valid (r_valid),
      .right_val   (r_val),
      .valid       (valid_a[g]),
      .val         (val_a[g]),
      .lt          (lt_a[g]),
      .eq          (eq_v[g])
    );
  end

  // A match anywhere in the row means the ID is already free.
  assign found    = |eq_v;
  assign head_val = val_a[0];

endmodule

`default_nettype wire

FILE: sv/smallest_free_id_allocator.sv
// Top level of the smallest free ID allocator: command port, frontier counter
// and result registers around the sorted cell chain. Depends on sfa_pkg, sfa_chain.
`timescale 1ns / 1ps
`default_nettype none

// Every transaction has a compare cycle, in which each cell of the chain checks
// its stored ID against the request, and an update cycle, in which the chain
// shifts and the result is registered. busy is high for the compare cycle only,
// so a new transaction can be accepted at the edge that registers the previous
// result. The result appears on the out_ ports for exactly one cycle under
// out_strobe; it cannot be held off, so a receiver must take it in that cycle.
// No clearing pass is needed after reset.
module smallest_free_id_allocator (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire                         in_command,
  input  wire [sfa_pkg::ID_BITS-1:0]  in_id_value,
  output logic                        out_strobe,
  output logic [sfa_pkg::ID_BITS-1:0] out_popped_id,
  output logic [1:0]                  out_status
);
  import sfa_pkg::*;

  logic                busy_r, busy_nxt;
  logic                phase_r;
  logic                cmd_r;
  logic [ID_BITS-1:0]  id_r;
  logic [ID_BITS-1:0]  frontier_r, frontier_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                strobe_r, strobe_nxt;
  logic [ID_BITS-1:0]  popped_r, popped_nxt;
  logic [1:0]          status_r, status_nxt;

  sfa_cell_ctl_t       ctl;
  logic                found;
  logic [ID_BITS-1:0]  head_val;
  logic                accept;
  logic                update;
  logic                full;

  assign accept = start && !busy;
  assign update = busy_r && !busy;
  assign full   = (count_r == CNT_BITS'(STORE_DEPTH));

  // busy_r marks a transaction in flight; busy covers its compare cycle.
  assign busy = busy_r && !phase_r;

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      id_r  <= in_id_value;
    end
  end

  // Update decision: chain operation, frontier, count and result.
  always_comb begin
    ctl          = '0;
    ctl.cmp      = busy;
    frontier_nxt = frontier_r;
    count_nxt    = count_r;
    popped_nxt   = '0;
    status_nxt   = ST_OK;
    strobe_nxt   = update;
    busy_nxt     = accept ? 1'b1 : (update ? 1'b0 : busy_r);
    if (update) begin
      case (cmd_r)
        CMD_POP: begin
          if (count_r != '0) begin
            ctl.pop    = 1'b1;
            count_nxt  = count_r - 1'b1;
            popped_nxt = head_val;
          end else if (frontier_r == '1) begin
            status_nxt = ST_EXHAUSTED;
          end else begin
            frontier_nxt = frontier_r + 1'b1;
            popped_nxt   = frontier_r + 1'b1;
          end
        end
        CMD_ADD: begin
          if ((id_r == '0) || (id_r > frontier_r) || found) begin
            status_nxt = ST_NO_CHANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
          status_nxt = ST_NO_CHANGE;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      phase_r    <= 1'b0;
      frontier_r <= '0;
      count_r    <= '0;
      strobe_r   <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      phase_r    <= busy;
      frontier_r <= frontier_nxt;
      count_r    <= count_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (update) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
  end

  sfa_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .req_id   (id_r),
    .found    (found),
    .head_val (head_val)
  );

  assign out_strobe    = strobe_r;
  assign out_popped_id = popped_r;
  assign out_status    = status_r;

endmodule

`default_nettype wire
